// File: rtl/core/rc5_ir_frame_receiver_top_macros.svh
// Assertion helpers for the RC5 receiver.
`ifndef RC5_IR_FRAME_RECEIVER_TOP_MACROS_SVH
`define RC5_IR_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RC5_ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rc5 check failed");
`define RC5_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rc5 check failed");
`else
`define RC5_ASSERT_IMPLIES(label, clk, rst, a, b)
`define RC5_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// File: rtl/core/rc5ir_pkg.sv
package rc5ir_pkg;

  localparam logic [4:0] HALFBIT_MAX = 5'd31;
  localparam logic [4:0] SHORT_FRAME = 5'd26;
  localparam logic [4:0] LONG_FRAME  = 5'd27;
  localparam logic [1:0] TOGGLE_NONE = 2'd2;

  localparam logic       DEF_ENABLE    = 1'b1;
  localparam logic [7:0] DEF_FULL_BIT  = 8'd35;
  localparam logic [6:0] DEF_TOLERANCE = 7'd7;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_FULL_BIT  = 2'd1,
    REG_TOLERANCE = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_EDGE    = 1'b0,
    REQ_TIMEOUT = 1'b1
  } req_t;

endpackage

// File: rtl/core/rc5_ir_frame_receiver_top.sv
// RC5 infrared frame receiver.
// Input channel (in_valid / in_stall): one word per pin-change edge or timeout;
// req_type selects which, edge_interval is the tick count since the last edge.
// Output channel (out_valid / out_stall): one word per timeout that closes a
// frame of 26 or 27 half-bits, with the 14 frame bits split into fields and a
// new_keypress flag from the toggle filter. Edges never produce a word.
// Config port: cfg_write with cfg_index / cfg_data; write only while idle.
// A word accepted goes into the input register and is decoded from there; for a
// frame, its result is loaded into the result register once that word may go on.
// Throughput: one word per cycle while in_stall is low; the decode is a compare
// and at most a one-bit shift between the input register and the result register.
// When the result register holds a word that is stalled, edges keep flowing;
// only a timeout that would produce a frame waits, and in_stall rises then.
// Reset: enable 1, full bit 35 ticks, tolerance 7, decoder cleared, no
// toggle seen, both channels empty.
`include "rc5_ir_frame_receiver_top_macros.svh"

module rc5_ir_frame_receiver_top
  import rc5ir_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] edge_interval,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       frame_valid,
  output logic       new_keypress,
  output logic [1:0] start_bits,
  output logic       toggle_flag,
  output logic [4:0] device_address,
  output logic [5:0] key_code
);

  logic       decoder_enable;
  logic [7:0] full_bit_ticks;
  logic [6:0] tolerance_ticks;

  logic       s1_valid;
  logic       s1_type;
  logic [7:0] s1_interval;

  logic        ignore_until_timeout, ignore_until_timeout_next;
  logic [4:0]  halfbit_count, halfbit_count_next;
  logic        edge_seen, edge_seen_next;
  logic        edge_parity, edge_parity_next;
  logic [13:0] shift_word, shift_word_next;
  logic [1:0]  last_toggle, last_toggle_next;

  logic        s1_emit, s1_go, in_accept;
  logic [6:0]  half_ticks;
  logic [8:0]  v_plus_tol;
  logic        in_half, in_full;
  logic [4:0]  cnt_a, cnt_b;
  logic [13:0] sh_a, sh_b;
  logic [13:0] frame_word;
  logic        frame_tog;

  assign s1_emit   = (s1_type == REQ_TIMEOUT) &&
                     (halfbit_count == SHORT_FRAME || halfbit_count == LONG_FRAME);
  assign s1_go     = !s1_emit || !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_go;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      decoder_enable  <= DEF_ENABLE;
      full_bit_ticks  <= DEF_FULL_BIT;
      tolerance_ticks <= DEF_TOLERANCE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ENABLE:    decoder_enable  <= cfg_data[0];
        REG_FULL_BIT:  full_bit_ticks  <= cfg_data;
        REG_TOLERANCE: tolerance_ticks <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_type     <= req_type;
      s1_interval <= edge_interval;
    end
  end

  // edge classification, strict windows, no wrap on the lower bound
  assign half_ticks = full_bit_ticks[7:1];
  assign v_plus_tol = {1'b0, s1_interval} + {2'b00, tolerance_ticks};
  assign in_half    = (v_plus_tol > {2'b00, half_ticks}) &&
                      ({1'b0, s1_interval} < ({2'b00, half_ticks} + {2'b00, tolerance_ticks}));
  assign in_full    = (v_plus_tol > {1'b0, full_bit_ticks}) &&
                      ({1'b0, s1_interval} < ({1'b0, full_bit_ticks} + {2'b00, tolerance_ticks}));

  // up to two half-bits; odd counts shift in the parity
  always_comb begin
    cnt_a = halfbit_count;
    sh_a  = shift_word;
    if (halfbit_count < HALFBIT_MAX) begin
      cnt_a = halfbit_count + 5'd1;
      if (cnt_a[0]) begin
        sh_a = {shift_word[12:0], edge_parity};
      end
    end
    cnt_b = cnt_a;
    sh_b  = sh_a;
    if (!in_half && cnt_a < HALFBIT_MAX) begin
      cnt_b = cnt_a + 5'd1;
      if (cnt_b[0]) begin
        sh_b = {sh_a[12:0], edge_parity};
      end
    end
  end

  assign frame_word = (halfbit_count == SHORT_FRAME) ? {shift_word[12:0], 1'b0} : shift_word;
  assign frame_tog  = frame_word[11];

  always_comb begin
    ignore_until_timeout_next = ignore_until_timeout;
    halfbit_count_next        = halfbit_count;
    edge_seen_next            = edge_seen;
    edge_parity_next          = edge_parity;
    shift_word_next           = shift_word;
    last_toggle_next          = last_toggle;
    if (s1_valid && s1_go) begin
      if (s1_type == REQ_TIMEOUT) begin
        if (s1_emit) begin
          last_toggle_next = {1'b0, frame_tog};
        end
        halfbit_count_next = '0;
        edge_seen_next     = 1'b0;
        edge_parity_next   = 1'b0;
        if (decoder_enable) begin
          ignore_until_timeout_next = 1'b0;
        end
      end else if (decoder_enable && !ignore_until_timeout) begin
        if (!edge_seen) begin
          shift_word_next  = '0;
          edge_seen_next   = 1'b1;
          edge_parity_next = !edge_parity;
        end else if (in_half || in_full) begin
          halfbit_count_next = cnt_b;
          shift_word_next    = sh_b;
          edge_parity_next   = !edge_parity;
        end else begin
          ignore_until_timeout_next = 1'b1;
          halfbit_count_next        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_until_timeout <= 1'b0;
      halfbit_count        <= '0;
      edge_seen            <= 1'b0;
      edge_parity          <= 1'b0;
      shift_word           <= '0;
      last_toggle          <= TOGGLE_NONE;
    end else begin
      ignore_until_timeout <= ignore_until_timeout_next;
      halfbit_count        <= halfbit_count_next;
      edge_seen            <= edge_seen_next;
      edge_parity          <= edge_parity_next;
      shift_word           <= shift_word_next;
      last_toggle          <= last_toggle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go && s1_emit) begin
      frame_valid    <= 1'b1;
      new_keypress   <= (last_toggle != {1'b0, frame_tog});
      start_bits     <= frame_word[13:12];
      toggle_flag    <= frame_tog;
      device_address <= frame_word[10:6];
      key_code       <= frame_word[5:0];
    end
  end

  `RC5_ASSERT_IMPLIES(a_ignore_zero_count, clk, rst, ignore_until_timeout, halfbit_count == 5'd0)
  `RC5_ASSERT_IMPLIES(a_count_needs_edge, clk, rst, !edge_seen, halfbit_count == 5'd0)
  `RC5_ASSERT_IMPLIES(a_out_from_timeout, clk, rst, $rose(out_valid), $past(s1_valid && s1_type == REQ_TIMEOUT))
  `RC5_ASSERT_NEXT(a_frame_clears, clk, rst, s1_valid && s1_go && s1_emit, halfbit_count == 5'd0 && out_valid)

endmodule

// File: tb/sv/rc5_ir_frame_receiver_top_test.sv
`timescale 1ns / 1ps

module rc5_ir_frame_receiver_top_test;
  import rc5ir_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic       valid;
    logic       keypress;
    logic [1:0] start;
    logic       toggle;
    logic [4:0] addr;
    logic [5:0] code;
  } frame_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       req_type;
  logic [7:0] edge_interval;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       frame_valid;
  logic       new_keypress;
  logic [1:0] start_bits;
  logic       toggle_flag;
  logic [4:0] device_address;
  logic [5:0] key_code;

  // decoder copy: settings and state
  logic        c_enable;
  logic [7:0]  c_full;
  logic [6:0]  c_tol;
  logic        m_ignore;
  logic [4:0]  m_count;
  logic        m_seen;
  logic        m_parity;
  logic [13:0] m_shift;
  logic [1:0]  m_last;

  frame_t frames_due[$];

  int   tx_idle_pct;
  int   rx_idle_pct;
  int   words_sent;
  int   frames_checked;
  int   stall_hits;
  int   errors;
  int   cycles;
  logic hold_req;
  logic hold_ack;
  int   hold_left;

  rc5_ir_frame_receiver_top dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver side: random stall plus an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_ack <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic flag(string msg);
    errors++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  function automatic logic in_band(int v, int ctr, int tol);
    return (v > ctr - tol) && (v < ctr + tol);
  endfunction

  task automatic reset_model();
    c_enable = DEF_ENABLE;
    c_full = DEF_FULL_BIT;
    c_tol = DEF_TOLERANCE;
    m_ignore = 1'b0;
    m_count = '0;
    m_seen = 1'b0;
    m_parity = 1'b0;
    m_shift = '0;
    m_last = TOGGLE_NONE;
  endtask

  task automatic take_halfbit();
    if (m_count != HALFBIT_MAX) begin
      m_count++;
      if (m_count[0]) m_shift = {m_shift[12:0], m_parity};
    end
  endtask

  task automatic decode_word(req_t kind, logic [7:0] interval);
    int          half;
    int          steps;
    logic [13:0] w;
    frame_t      f;
    half = c_full >> 1;
    if (kind == REQ_TIMEOUT) begin
      if (m_count == SHORT_FRAME || m_count == LONG_FRAME) begin
        w = (m_count == SHORT_FRAME) ? {m_shift[12:0], 1'b0} : m_shift;
        f.valid = 1'b1;
        f.keypress = (m_last != {1'b0, w[11]});
        if (f.keypress) m_last = {1'b0, w[11]};
        f.start = w[13:12];
        f.toggle = w[11];
        f.addr = w[10:6];
        f.code = w[5:0];
        frames_due.push_back(f);
      end
      m_count = '0;
      m_seen = 1'b0;
      m_parity = 1'b0;
      if (c_enable) m_ignore = 1'b0;
    end else if (c_enable && !m_ignore) begin
      if (!m_seen) begin
        m_shift = '0;
        m_seen = 1'b1;
        m_parity = ~m_parity;
      end else begin
        if (in_band(interval, half, c_tol)) steps = 1;
        else if (in_band(interval, c_full, c_tol)) steps = 2;
        else steps = 0;
        if (steps == 0) begin
          m_ignore = 1'b1;
          m_count = '0;
        end else begin
          repeat (steps) take_halfbit();
          m_parity = ~m_parity;
        end
      end
    end
  endtask

  task automatic check_frame(frame_t want);
    frame_t got;
    got = {frame_valid, new_keypress, start_bits, toggle_flag, device_address, key_code};
    frames_checked++;
    if (got.valid !== want.valid)
      flag($sformatf("frame_valid got %0d want %0d", got.valid, want.valid));
    if (got.keypress !== want.keypress)
      flag($sformatf("new_keypress got %0d want %0d", got.keypress, want.keypress));
    if (got.start !== want.start)
      flag($sformatf("start_bits got %0d want %0d", got.start, want.start));
    if (got.toggle !== want.toggle)
      flag($sformatf("toggle_flag got %0d want %0d", got.toggle, want.toggle));
    if (got.addr !== want.addr)
      flag($sformatf("device_address got %0d want %0d", got.addr, want.addr));
    if (got.code !== want.code)
      flag($sformatf("key_code got %0d want %0d", got.code, want.code));
  endtask

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) flag("result word with no frame pending");
      else check_frame(frames_due.pop_front());
    end
  end

  task automatic send_word(req_t kind, logic [7:0] interval);
    logic taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    edge_interval <= interval;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (!taken) stall_hits++;
      @(posedge clk);
    end while (!taken);
    decode_word(kind, interval);
    words_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ENABLE:    c_enable = value[0];
      REG_FULL_BIT:  c_full = value;
      REG_TOLERANCE: c_tol = value[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic en, logic [7:0] full, logic [6:0] tol);
    settle();
    write_reg(REG_ENABLE, {7'd0, en});
    write_reg(REG_FULL_BIT, full);
    write_reg(REG_TOLERANCE, {1'b0, tol});
  endtask

  // steps 1 or 2 aim at a half or whole bit, anything else at a bad interval
  function automatic logic [7:0] pick_interval(int steps);
    int full;
    int tol;
    int half;
    int lo;
    int hi;
    int v;
    int i;
    full = c_full;
    tol = c_tol;
    half = full >> 1;
    if (steps == 1) begin
      lo = half - tol + 1;
      hi = half + tol - 1;
    end else if (steps == 2) begin
      lo = full - tol + 1;
      hi = full + tol - 1;
      if (lo < half + tol) lo = half + tol;
    end else begin
      for (i = 0; i < 20; i++) begin
        v = $urandom_range(255);
        if (!in_band(v, half, tol) && !in_band(v, full, tol)) return 8'(v);
      end
      return 8'($urandom_range(255));
    end
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    if (lo > hi) return 8'($urandom_range(255));
    return 8'($urandom_range(hi, lo));
  endfunction

  task automatic send_frame(int target, int noise_pct);
    int count;
    int steps;
    count = 0;
    send_word(REQ_EDGE, 8'($urandom_range(255)));
    while (count < target) begin
      steps = (target - count == 1) ? 1 : $urandom_range(2, 1);
      send_word(REQ_EDGE, ($urandom_range(99) < noise_pct) ? pick_interval(0)
                                                           : pick_interval(steps));
      count += steps;
    end
    send_word(REQ_TIMEOUT, 8'($urandom_range(255)));
  endtask

  task automatic send_noise();
    int k;
    k = $urandom_range(5, 1);
    repeat (k) send_word(($urandom_range(3) == 0) ? REQ_TIMEOUT : REQ_EDGE,
                         8'($urandom_range(255)));
  endtask

  task automatic random_config();
    logic [7:0] full;
    logic [6:0] tol;
    int         cap;
    full = 8'($urandom_range(255, 4));
    cap = full / 4 + 1;
    if (cap > 127) cap = 127;
    tol = ($urandom_range(2) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(cap, 1));
    set_config($urandom_range(9) != 0, full, tol);
  endtask

  // default timing: half bit 11..23, whole bit 29..41, strict bounds just outside
  task automatic test_boundaries();
    int i;
    send_word(REQ_TIMEOUT, 8'd0);
    send_word(REQ_EDGE, 8'd255);
    send_word(REQ_EDGE, 8'd11);
    send_word(REQ_EDGE, 8'd23);
    send_word(REQ_EDGE, 8'd29);
    for (i = 0; i < 11; i++) send_word(REQ_EDGE, i[0] ? 8'd29 : 8'd41);
    send_word(REQ_TIMEOUT, 8'd255);
    send_word(REQ_EDGE, 8'd0);
    send_word(REQ_EDGE, 8'd24);
    send_word(REQ_EDGE, 8'd17);
    send_word(REQ_TIMEOUT, 8'd0);
    send_word(REQ_EDGE, 8'd10);
    send_word(REQ_EDGE, 8'd10);
    send_word(REQ_TIMEOUT, 8'd0);
    settle();
  endtask

  task automatic test_enable_gate();
    int i;
    set_config(1'b1, 8'd35, 7'd7);
    send_word(REQ_EDGE, 8'd0);
    for (i = 0; i < 13; i++) send_word(REQ_EDGE, 8'd35);
    settle();
    write_reg(REG_ENABLE, 8'd0);
    send_word(REQ_EDGE, 8'd17);
    // frame still comes out while disabled
    send_word(REQ_TIMEOUT, 8'd0);
    settle();
    write_reg(REG_ENABLE, 8'd1);
    send_word(REQ_EDGE, 8'd0);
    send_word(REQ_EDGE, 8'd100);
    settle();
    write_reg(REG_ENABLE, 8'd0);
    // ignore flag survives a timeout while disabled
    send_word(REQ_TIMEOUT, 8'd0);
    settle();
    write_reg(REG_ENABLE, 8'd1);
    send_frame(26, 0);
    send_frame(27, 0);
    settle();
  endtask

  task automatic test_extreme_settings();
    logic [7:0] fulls[7];
    logic [6:0] tols[7];
    int         i;
    fulls = '{8'd4, 8'd4, 8'd255, 8'd255, 8'd4, 8'd255, 8'd35};
    tols = '{7'd1, 7'd127, 7'd127, 7'd0, 7'd0, 7'd1, 7'd7};
    for (i = 0; i < 7; i++) begin
      set_config(i != 6, fulls[i], tols[i]);
      send_frame(26, 0);
      send_frame(27, 0);
      send_noise();
    end
    settle();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_words);
    int stop_at;
    int next_cfg;
    int pick;
    settle();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = words_sent + n_words;
    next_cfg = words_sent;
    while (words_sent < stop_at) begin
      if (words_sent >= next_cfg) begin
        random_config();
        next_cfg = words_sent + 90;
      end
      pick = $urandom_range(99);
      if (pick < 70) send_frame(26 + $urandom_range(1), ($urandom_range(3) == 0) ? 8 : 0);
      else if (pick < 80) send_frame($urandom_range(34, 28), 0);
      else if (pick < 88) send_frame($urandom_range(25, 2), 0);
      else send_noise();
    end
    settle();
  endtask

  // result stage held for a long stretch while frames keep coming
  task automatic test_backpressure();
    int i;
    set_config(1'b1, 8'd35, 7'd7);
    hold_req <= ~hold_req;
    @(posedge clk);
    for (i = 0; i < 5; i++) send_frame(26 + (i % 2), 0);
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_EDGE;
    edge_interval = '0;
    hold_req = 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct = 54;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_boundaries();
    test_enable_gate();
    test_random_traffic(11, 54, 220);
    tx_idle_pct = 54;
    rx_idle_pct = 11;
    test_extreme_settings();
    test_random_traffic(54, 11, 220);
    test_random_traffic(0, 0, 160);
    test_backpressure();
    settle();

    $display("covered %0d input words, %0d decoded frames checked, %0d cycles",
             words_sent, frames_checked, cycles);
    $display("input stalled %0d cycles; %0d mismatches", stall_hits, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
